/* rtl/core/owrs_pkg.sv */
// ----------------------------------------------------------------------------
// owrs_pkg
// Shared types and constants of the ROM search decision core: operation
// codes, the search state record and the per-request result flags.
// ----------------------------------------------------------------------------
`default_nettype none

package owrs_pkg;

  localparam int unsigned RomBits     = 64;
  localparam int unsigned IdxW        = $clog2(RomBits);
  localparam int unsigned PosW        = IdxW + 1;
  localparam int unsigned FamW        = 4;
  localparam int unsigned FamilyLimit = 9;
  localparam int unsigned OpW         = 2;

  typedef enum logic [OpW-1:0] {
    OpRestart = 2'd0,
    OpBegin   = 2'd1,
    OpPair    = 2'd2
  } owrs_op_e;

  typedef struct packed {
    logic [RomBits-1:0] rom_bits;
    logic [PosW-1:0]    last_disc;
    logic [FamW-1:0]    last_fam_disc;
    logic               last_dev_seen;
    logic [PosW-1:0]    bit_pos;
    logic [PosW-1:0]    last_zero_pos;
    logic               pass_active;
  } owrs_state_t;

  typedef struct packed {
    logic write_valid;
    logic direction;
    logic done;
    logic found;
  } owrs_res_t;

  localparam owrs_state_t StateReset = '{
    rom_bits:      '0,
    last_disc:     '0,
    last_fam_disc: '0,
    last_dev_seen: 1'b0,
    bit_pos:       PosW'(1),
    last_zero_pos: '0,
    pass_active:   1'b0
  };

endpackage

`default_nettype wire

/* rtl/core/owrs_decide.sv */
// ----------------------------------------------------------------------------
// owrs_decide
// Next-state and result logic of the ROM search for one request: restart,
// begin of a pass, or one received bit pair.
// ----------------------------------------------------------------------------
`default_nettype none

module owrs_decide (
  input  owrs_pkg::owrs_state_t    state_i,
  input  logic [owrs_pkg::OpW-1:0] opcode_i,
  input  logic                     presence_i,
  input  logic                     id_bit_i,
  input  logic                     comp_bit_i,
  output owrs_pkg::owrs_state_t    state_o,
  output owrs_pkg::owrs_res_t      res_o
);
  import owrs_pkg::*;

  logic [PosW-1:0] pos;
  logic [PosW-1:0] pos_m1;
  logic [IdxW-1:0] idx;
  logic            dir;
  logic            last_pos;
  owrs_state_t     upd;

  assign pos      = state_i.bit_pos;
  assign pos_m1   = pos - PosW'(1);
  assign idx      = pos_m1[IdxW-1:0];
  assign last_pos = (pos >= PosW'(RomBits));

  always_comb begin
    if (id_bit_i != comp_bit_i) begin
      dir = id_bit_i;
    end else if (pos < state_i.last_disc) begin
      dir = state_i.rom_bits[idx];
    end else begin
      dir = (pos == state_i.last_disc);
    end
  end

  always_comb begin
    state_o = state_i;
    res_o   = '0;
    upd     = state_i;
    case (opcode_i)
      OpRestart: begin
        state_o = StateReset;
      end
      OpBegin: begin
        state_o.bit_pos       = PosW'(1);
        state_o.last_zero_pos = '0;
        state_o.pass_active   = 1'b0;
        if (state_i.last_dev_seen || !presence_i) begin
          state_o.last_disc     = '0;
          state_o.last_fam_disc = '0;
          state_o.last_dev_seen = 1'b0;
          res_o.done            = 1'b1;
        end else begin
          state_o.pass_active = 1'b1;
        end
      end
      OpPair: begin
        if (state_i.pass_active) begin
          if (id_bit_i && comp_bit_i) begin
            state_o.last_disc     = '0;
            state_o.last_fam_disc = '0;
            state_o.last_dev_seen = 1'b0;
            state_o.pass_active   = 1'b0;
            res_o.done            = 1'b1;
          end else begin
            if ((id_bit_i == comp_bit_i) && !dir) begin
              upd.last_zero_pos = pos;
              if (pos < PosW'(FamilyLimit)) begin
                upd.last_fam_disc = pos[FamW-1:0];
              end
            end
            upd.rom_bits[idx] = dir;
            res_o.write_valid = 1'b1;
            res_o.direction   = dir;
            if (last_pos) begin
              upd.pass_active = 1'b0;
              upd.bit_pos     = PosW'(1);
              upd.last_disc   = upd.last_zero_pos;
              res_o.done      = 1'b1;
              if (upd.last_zero_pos == '0) begin
                upd.last_dev_seen = 1'b1;
              end
              if (upd.rom_bits[7:0] == 8'h00) begin
                upd.last_disc     = '0;
                upd.last_fam_disc = '0;
                upd.last_dev_seen = 1'b0;
              end else begin
                res_o.found = 1'b1;
              end
            end else begin
              upd.bit_pos = pos + PosW'(1);
            end
            state_o = upd;
          end
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/onewire_rom_search_step_core.sv */
// ----------------------------------------------------------------------------
// onewire_rom_search_step_core
// Decision core of the 1-Wire ROM search: chooses the direction bit for each
// received bit pair and reports the found ROM code at the end of a pass.
// ----------------------------------------------------------------------------
//  Channel | Handshake              | Payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid_i / in_ready_o | opcode, presence, id_bit, comp_bit
//  out     | out_valid_o/out_ready_i | write_valid, direction, done_res, found,
//          |                        | rom_code, family_discrepancy
//
// Each request is decided in the cycle it is accepted and its result appears
// in the output register on the next cycle: one request per cycle unless the
// output stalls. A new request is accepted whenever the output register is
// empty or is being taken in the same cycle, so a stalled output stops the
// input only then. Reset clears state and out_valid only; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module onewire_rom_search_step_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [owrs_pkg::OpW-1:0]     opcode_i,
  input  logic                         presence_i,
  input  logic                         id_bit_i,
  input  logic                         comp_bit_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         write_valid_o,
  output logic                         direction_o,
  output logic                         done_res_o,
  output logic                         found_o,
  output logic [owrs_pkg::RomBits-1:0] rom_code_o,
  output logic [owrs_pkg::FamW-1:0]    family_discrepancy_o
);
  import owrs_pkg::*;

  owrs_state_t     state_q;
  owrs_state_t     state_d;
  owrs_res_t       res_d;
  owrs_res_t       res_q;
  logic [RomBits-1:0] rom_q;
  logic [FamW-1:0]    fam_q;
  logic            out_valid_q;
  logic            in_take;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_take    = in_valid_i && in_ready_o;

  owrs_decide u_decide (
    .state_i    (state_q),
    .opcode_i   (opcode_i),
    .presence_i (presence_i),
    .id_bit_i   (id_bit_i),
    .comp_bit_i (comp_bit_i),
    .state_o    (state_d),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateReset;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        state_q <= state_d;
      end
      if (in_take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      res_q <= res_d;
      rom_q <= state_d.rom_bits;
      fam_q <= state_d.last_fam_disc;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign write_valid_o        = res_q.write_valid;
  assign direction_o          = res_q.direction;
  assign done_res_o           = res_q.done;
  assign found_o              = res_q.found;
  assign rom_code_o           = rom_q;
  assign family_discrepancy_o = fam_q;

endmodule

`default_nettype wire

/* rtl/core/onewire_rom_search_step_checker.sv */
// ----------------------------------------------------------------------------
// onewire_rom_search_step_checker
// Port-level checks of the ROM search core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module onewire_rom_search_step_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic [owrs_pkg::OpW-1:0]     opcode_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         write_valid_o,
  input logic                         direction_o,
  input logic                         done_res_o,
  input logic                         found_o,
  input logic [owrs_pkg::RomBits-1:0] rom_code_o,
  input logic [owrs_pkg::FamW-1:0]    family_discrepancy_o
);
  import owrs_pkg::*;

  // A restart leaves an empty ROM code and no pass result.
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (opcode_i == OpRestart) |=>
      out_valid_o && (rom_code_o == '0) && (family_discrepancy_o == '0) &&
      !done_res_o && !write_valid_o)
    else $error("restart did not clear the search state");

  a_found_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> done_res_o)
    else $error("found reported without the end of a pass");

  a_dir_needs_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && direction_o |-> write_valid_o)
    else $error("direction set without a write");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled although the output is free");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rom_code_o) &&
      $stable(done_res_o) && $stable(found_o) && $stable(direction_o))
    else $error("stalled result changed");

endmodule

bind onewire_rom_search_step_core onewire_rom_search_step_checker u_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_valid_i),
  .in_ready_o           (in_ready_o),
  .opcode_i             (opcode_i),
  .out_valid_o          (out_valid_o),
  .out_ready_i          (out_ready_i),
  .write_valid_o        (write_valid_o),
  .direction_o          (direction_o),
  .done_res_o           (done_res_o),
  .found_o              (found_o),
  .rom_code_o           (rom_code_o),
  .family_discrepancy_o (family_discrepancy_o)
);

`default_nettype wire
